/* rtl/core/mrwt_pkg.sv */
// ----------------------------------------------------------------------------
// mrwt_pkg
// Shared types and constants of the Miller-Rabin witness test unit.
// ----------------------------------------------------------------------------
package mrwt_pkg;

  // Verdict codes carried on the result word
  localparam logic [1:0] VERDICT_TWO       = 2'd0;
  localparam logic [1:0] VERDICT_PROBABLE  = 2'd1;
  localparam logic [1:0] VERDICT_COMPOSITE = 2'd2;
  localparam logic [1:0] VERDICT_REJECTED  = 2'd3;

  // Fixed field widths of the stream words
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 8;

  // Status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

/* rtl/core/mrwt_modmul.sv */
// ----------------------------------------------------------------------------
// mrwt_modmul
// Iterative shift-and-add modular multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mrwt_modmul #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_WIDTH-1:0]  x,
  input  logic [NUM_WIDTH-1:0]  y,
  input  logic [NUM_WIDTH-1:0]  m,
  output mrwt_pkg::mm_stat_t    stat,
  output logic [NUM_WIDTH-1:0]  result
);
  import mrwt_pkg::*;

  logic                 busy;
  logic [NUM_WIDTH-1:0] acc;
  logic [NUM_WIDTH-1:0] addend;
  logic [NUM_WIDTH-1:0] mult;
  logic [NUM_WIDTH-1:0] modulus;
  logic [NUM_WIDTH:0]   sum;
  logic [NUM_WIDTH:0]   dbl;
  logic [NUM_WIDTH-1:0] acc_next;
  logic [NUM_WIDTH-1:0] addend_next;

  // Add and double with full reduction against the modulus
  always_comb begin
    sum = {1'b0, acc} + {1'b0, addend};
    dbl = {addend, 1'b0};
    if (sum >= {1'b0, modulus}) begin
      sum = sum - {1'b0, modulus};
    end
    if (dbl >= {1'b0, modulus}) begin
      dbl = dbl - {1'b0, modulus};
    end
    acc_next    = mult[0] ? sum[NUM_WIDTH-1:0] : acc;
    addend_next = dbl[NUM_WIDTH-1:0];
  end

  // Busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && mult == '0) begin
      busy <= 1'b0;
    end
  end

  // Load operands or advance one bit
  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= '0;
      addend  <= x;
      mult    <= y;
      modulus <= m;
    end else if (busy && mult != '0) begin
      acc    <= acc_next;
      addend <= addend_next;
      mult   <= mult >> 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = busy && (mult == '0);
  assign result    = acc;

endmodule

/* rtl/core/miller_rabin_witness_test_unit.sv */
// ----------------------------------------------------------------------------
// A rejected candidate or two is settled by the input check alone; any other
//   candidate runs the full round on the shared shift-and-add multiplier,
//   which takes one bit per cycle.
// Throughput: one word at a time; a new word is taken once the verdict is
//   handed to the output register.
// Reset: synchronous, clears the sequencer, multiplier and output valid.
// ----------------------------------------------------------------------------
// miller_rabin_witness_test_unit
// One strong-probable-prime round per input word, on one shared modular
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test_unit #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [31:0] candidate, [63:32] witness_base
  input  logic [mrwt_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [1:0] verdict, [7:2] zero
  output logic [mrwt_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import mrwt_pkg::*;

  localparam int unsigned CW = (NUM_WIDTH < FIELD_W) ? NUM_WIDTH : FIELD_W;
  localparam int unsigned SW = $clog2(NUM_WIDTH + 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_REDUCE = 8'b0000_0010,
    ST_DECOMP = 8'b0000_0100,
    ST_POW    = 8'b0000_1000,
    ST_POW_R  = 8'b0001_0000,
    ST_POW_S  = 8'b0010_0000,
    ST_SQ     = 8'b0100_0000,
    ST_SQ_W   = 8'b1000_0000
  } state_t;

  state_t               state;
  logic                 out_pend;
  logic [1:0]           verdict;
  logic [1:0]           verdict_out;
  logic [NUM_WIDTH-1:0] n;
  logic [NUM_WIDTH-1:0] d;
  logic [SW-1:0]        s;
  logic [NUM_WIDTH-1:0] r;
  logic [NUM_WIDTH-1:0] sq;

  logic [NUM_WIDTH-1:0] n_in;
  logic [NUM_WIDTH-1:0] a_in;
  logic                 accept;
  logic                 mm_start;
  logic [NUM_WIDTH-1:0] mm_x;
  logic [NUM_WIDTH-1:0] mm_y;
  logic [NUM_WIDTH-1:0] mm_m;
  logic [NUM_WIDTH-1:0] mm_res;
  mm_stat_t             mm_stat;
  logic                 out_free;

  // Take the low bits of each field
  assign n_in = NUM_WIDTH'(s_tdata[CW-1:0]);
  assign a_in = NUM_WIDTH'(s_tdata[FIELD_W+CW-1:FIELD_W]);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && !out_pend;
  assign accept   = s_tvalid && s_tready;

  // Select operands for the shared multiplier
  always_comb begin
    mm_start = 1'b0;
    mm_x     = sq;
    mm_y     = sq;
    mm_m     = n;
    case (state)
      ST_IDLE: begin
        mm_x     = NUM_WIDTH'(1);
        mm_y     = a_in;
        mm_m     = n_in;
        mm_start = accept && n_in[0] && (n_in > NUM_WIDTH'(2));
      end
      ST_POW: begin
        if (d != '0) begin
          mm_start = 1'b1;
          if (d[0]) begin
            mm_x = r;
            mm_y = sq;
          end
        end
      end
      ST_POW_R: begin
        mm_start = mm_stat.done && (d != NUM_WIDTH'(1));
      end
      ST_SQ: begin
        mm_x     = r;
        mm_y     = r;
        mm_start = (s != '0) && !out_pend;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  mrwt_modmul #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .m      (mm_m),
    .stat   (mm_stat),
    .result (mm_res)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_pend <= 1'b0;
    end else begin
      if (out_pend && out_free) begin
        out_pend <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            n <= n_in;
            d <= n_in - NUM_WIDTH'(1);
            s <= '0;
            if (n_in < NUM_WIDTH'(2)) begin
              verdict  <= VERDICT_REJECTED;
              out_pend <= 1'b1;
            end else if (n_in == NUM_WIDTH'(2)) begin
              verdict  <= VERDICT_TWO;
              out_pend <= 1'b1;
            end else if (!n_in[0]) begin
              verdict  <= VERDICT_REJECTED;
              out_pend <= 1'b1;
            end else begin
              state <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mm_stat.done) begin
            sq    <= mm_res;
            r     <= NUM_WIDTH'(1);
            state <= ST_DECOMP;
          end
        end
        ST_DECOMP: begin
          // strip factors of two from n-1
          if (!d[0]) begin
            d <= d >> 1;
            s <= s + SW'(1);
          end else begin
            state <= ST_POW;
          end
        end
        ST_POW: begin
          if (d == '0) begin
            state <= ST_SQ;
          end else if (d[0]) begin
            state <= ST_POW_R;
          end else begin
            state <= ST_POW_S;
          end
        end
        ST_POW_R: begin
          if (mm_stat.done) begin
            r <= mm_res;
            if (d == NUM_WIDTH'(1)) begin
              // last exponent bit: skip the unused square
              d     <= '0;
              state <= ST_POW;
            end else begin
              state <= ST_POW_S;
            end
          end
        end
        ST_POW_S: begin
          if (mm_stat.done) begin
            sq    <= mm_res;
            d     <= d >> 1;
            state <= ST_POW;
          end
        end
        ST_SQ: begin
          if (!out_pend) begin
            if (s == '0) begin
              verdict  <= (r != NUM_WIDTH'(1)) ? VERDICT_COMPOSITE : VERDICT_PROBABLE;
              out_pend <= 1'b1;
              state    <= ST_IDLE;
            end else begin
              state <= ST_SQ_W;
            end
          end
        end
        ST_SQ_W: begin
          if (mm_stat.done) begin
            // nontrivial square root of one
            if (mm_res == NUM_WIDTH'(1) && r != NUM_WIDTH'(1)
                && r != n - NUM_WIDTH'(1)) begin
              verdict  <= VERDICT_COMPOSITE;
              out_pend <= 1'b1;
              state    <= ST_IDLE;
            end else begin
              r     <= mm_res;
              s     <= s - SW'(1);
              state <= ST_SQ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: load the pending verdict, drop valid when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_pend && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_pend && out_free) begin
      verdict_out <= verdict;
    end
  end

  assign m_tdata = {(OUT_DATA_W - 2)'(0), verdict_out};

endmodule

/* test/miller_rabin_witness_test_unit_test.sv */
// ----------------------------------------------------------------------------
// miller_rabin_witness_test_unit_test
// Self-checking bench for the Miller-Rabin witness test unit. A queue of
// candidate/base words feeds a stream driver. Each accepted word is scored
// against a software round, and each verdict word is checked in order.
// The stimulus opens with edge values, primes, strong pseudoprimes and bases
// that reduce to 0, 1 and n-1. It then mixes in random rounds, with random
// gaps and stalls, one long output hold-off and two full drains.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test_unit_test;
  import mrwt_pkg::*;

  localparam int unsigned PAD_W      = OUT_DATA_W - 2;
  localparam int unsigned CALM_WORDS = 12;
  localparam int unsigned HOLD_CYC   = 8000;
  localparam int unsigned SETTLE_CYC = 2300;

  typedef struct {
    logic [FIELD_W-1:0] candidate;
    logic [FIELD_W-1:0] witness_base;
    bit                 drain_first;
  } round_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  round_word_t  round_q[$];
  logic [1:0]   verdict_q[$];
  int unsigned  words_sent = 0;
  int unsigned  verdicts_seen = 0;
  int unsigned  send_gap = 0;
  int unsigned  stall_left = 0;
  int unsigned  mismatches = 0;
  logic         hold_off = 1'b0;

  miller_rabin_witness_test_unit #(
    .NUM_WIDTH(FIELD_W)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // Clock: period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Operands stay below 2^32, so the 64-bit product never wraps
  function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                             longint unsigned m);
    return (x * y) % m;
  endfunction

  // One strong-probable-prime round on a candidate/base pair
  function automatic logic [1:0] round_verdict(logic [FIELD_W-1:0] cand,
                                               logic [FIELD_W-1:0] base);
    longint unsigned n, odd_part, cur, prev, sq, e;
    int unsigned     twos, i;
    n = cand;
    if (n < 2) return VERDICT_REJECTED;
    if (n == 2) return VERDICT_TWO;
    if (n[0] == 1'b0) return VERDICT_REJECTED;
    // split n-1 into odd_part * 2^twos
    odd_part = n - 1;
    twos = 0;
    while (odd_part[0] == 1'b0) begin
      odd_part = odd_part >> 1;
      twos++;
    end
    // reduced base raised to the odd part
    cur = 1;
    sq = base % n;
    e = odd_part;
    while (e != 0) begin
      if (e[0]) cur = mulmod(cur, sq, n);
      sq = mulmod(sq, sq, n);
      e = e >> 1;
    end
    // square up, watching for a nontrivial root of one
    prev = cur;
    for (i = 0; i < twos; i++) begin
      cur = mulmod(cur, cur, n);
      if (cur == 1 && prev != 1 && prev != n - 1) return VERDICT_COMPOSITE;
      prev = cur;
    end
    return (cur != 1) ? VERDICT_COMPOSITE : VERDICT_PROBABLE;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 300);
  endfunction

  function automatic void add_round(logic [FIELD_W-1:0] cand, logic [FIELD_W-1:0] base,
                                    bit drain);
    round_word_t w;
    w.candidate = cand;
    w.witness_base = base;
    w.drain_first = drain;
    round_q.push_back(w);
  endfunction

  // Sender: score each accepted word, then offer the next one
  always @(posedge clk) begin : drive
    round_word_t w;
    bit          accepted;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      accepted = s_tvalid && s_tready;
      if (accepted) begin
        verdict_q.push_back(round_verdict(s_tdata[FIELD_W-1:0],
                                          s_tdata[2*FIELD_W-1:FIELD_W]));
        words_sent <= words_sent + 1;
      end
      if (!s_tvalid || accepted) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (round_q.size() != 0 &&
                     !(round_q[0].drain_first &&
                       (words_sent + accepted) != verdicts_seen)) begin
          w = round_q.pop_front();
          s_tdata  <= {w.witness_base, w.candidate};
          s_tvalid <= 1'b1;
          send_gap <= (words_sent < CALM_WORDS) ? 0 : idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (verdicts_seen >= CALM_WORDS && $urandom_range(0, 5) == 0) begin
      stall_left <= idle_len();
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Checker: compare each verdict word with the oldest expectation
  always @(posedge clk) begin : check
    logic [1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      verdicts_seen <= verdicts_seen + 1;
      if (verdict_q.size() == 0) begin
        mismatches++;
        $display("%0t: verdict word expected none, actual %h", $time, m_tdata);
      end else begin
        want = verdict_q.pop_front();
        if (m_tdata !== {{PAD_W{1'b0}}, want}) begin
          mismatches++;
          $display("%0t: verdict word expected %h, actual %h", $time,
                   {{PAD_W{1'b0}}, want}, m_tdata);
        end
      end
    end
  end

  // Long output hold-off so the unit backs up and stalls its input
  initial begin
    while (words_sent < 40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Run limit
  initial begin
    #60000000;
    $display("Mismatches found");
    $finish;
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic [FIELD_W-1:0] primes[14];
    logic [FIELD_W-1:0] liars[12];
    logic [FIELD_W-1:0] n, b;
    int unsigned        k, r;
    primes = '{32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd97, 32'd65537, 32'd2147483647,
               32'd4294967291, 32'd4294967279, 32'd1000000007, 32'd998244353,
               32'd3221225473, 32'd2013265921};
    liars = '{32'd2047, 32'd1373653, 32'd25326001, 32'd3215031751, 32'd561, 32'd1105,
              32'd1729, 32'd2465, 32'd2821, 32'd6601, 32'd8911, 32'd41041};

    // Directed: rejections, two, base edges, primes and pseudoprimes
    add_round(32'd0, 32'd0, 1'b0);
    add_round(32'd1, 32'hFFFF_FFFF, 1'b0);
    add_round(32'd2, 32'd5, 1'b0);
    add_round(32'd2, 32'd0, 1'b0);
    add_round(32'd4, 32'd3, 1'b0);
    add_round(32'hFFFF_FFFE, 32'd7, 1'b0);
    add_round(32'd3, 32'd2, 1'b0);
    add_round(32'd3, 32'd3, 1'b0);
    add_round(32'hFFFF_FFFF, 32'd2, 1'b0);
    add_round(32'd4294967291, 32'd2, 1'b0);
    add_round(32'd4294967291, 32'hFFFF_FFFF, 1'b0);
    add_round(32'd4294967291, 32'd4294967291, 1'b0);
    add_round(32'd4294967291, 32'd4294967290, 1'b0);
    add_round(32'd4294967291, 32'd1, 1'b0);
    add_round(32'd2047, 32'd2, 1'b0);
    add_round(32'd2047, 32'd3, 1'b0);
    add_round(32'd3215031751, 32'd2, 1'b0);
    add_round(32'd3215031751, 32'd7, 1'b0);
    add_round(32'd3215031751, 32'd11, 1'b0);
    add_round(32'd561, 32'd2, 1'b0);
    add_round(32'd65537, 32'd3, 1'b0);
    add_round(32'd9, 32'd8, 1'b0);
    add_round(32'd25, 32'd7, 1'b0);
    add_round(32'h8000_0001, 32'hAAAA_AAAA, 1'b0);

    // Random rounds, mostly odd candidates that run the full round
    for (k = 0; k < 166; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        n = $urandom();
        b = $urandom();
      end else if (r < 20) begin
        n = $urandom_range(0, 64);
        b = $urandom();
      end else if (r < 45) begin
        n = primes[$urandom_range(0, 13)];
        b = $urandom();
      end else if (r < 57) begin
        n = liars[$urandom_range(0, 11)];
        case ($urandom_range(0, 4))
          0: b = 32'd2;
          1: b = 32'd3;
          2: b = 32'd5;
          3: b = 32'd7;
          default: b = $urandom();
        endcase
      end else if (r < 67) begin
        n = $urandom() | 32'd1;
        if (n < 3) n = 32'd3;
        case ($urandom_range(0, 4))
          0: b = 32'd0;
          1: b = n;
          2: b = 32'd1;
          3: b = n - 1;
          default: b = n + 1;
        endcase
      end else begin
        n = $urandom() | 32'd1;
        if ($urandom_range(0, 1) == 1) n[FIELD_W-1] = 1'b1;
        b = $urandom();
      end
      // wait for a full drain before the first random word and once more
      add_round(n, b, (k == 0 || k == 80));
    end

    // Let everything come back, then allow for a stray late word
    while (rst) @(posedge clk);
    while (round_q.size() != 0 || s_tvalid) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Reset
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

endmodule
